// ===== hw/rtl/fir16_pkg.sv =====
// Shared types, constants and the tap weight function for the 16-tap FIR block.
// Used by every module of the filter; depends on nothing.
package fir16_pkg;

  // Filter geometry and arithmetic widths.
  localparam int TAP_COUNT   = 16;
  localparam int SAMPLE_W    = 8;
  localparam int ACC_W       = 16;
  localparam int SCALED_W    = ACC_W + 2;
  localparam int GROUP_SIZE  = 4;
  localparam int GROUP_COUNT = (TAP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int WEIGHT_MAX  = (TAP_COUNT + 1) / 2;
  localparam int WEIGHT_W    = $clog2(WEIGHT_MAX + 1);

  // Output saturation limits.
  localparam int OUT_MAX = 127;
  localparam int OUT_MIN = -128;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef sample_t [TAP_COUNT-1:0]    tap_vec_t;
  typedef acc_t [GROUP_COUNT-1:0]     part_vec_t;

  // Symmetric weight of tap idx (0 is the newest sample): 1, 2, ..., 8, 8, ..., 2, 1.
  function automatic logic [WEIGHT_W-1:0] tap_weight(input int idx);
    int a;
    int b;
    a = idx + 1;
    b = TAP_COUNT - idx;
    return WEIGHT_W'((a < b) ? a : b);
  endfunction

endpackage

// ===== hw/rtl/fir16_delay.sv =====
// Input register and delay line of the FIR block.
// Depends on fir16_pkg for the sample and tap vector types.
module fir16_delay (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  fir16_pkg::sample_t  sample_i,
  output logic                valid_o,
  input  logic                ready_i,
  output fir16_pkg::tap_vec_t taps_o
);

  logic                valid_r;
  fir16_pkg::tap_vec_t taps_r;
  fir16_pkg::tap_vec_t taps_nxt;

  // The stage frees up when it is empty or its content moves on.
  assign ready_o = !valid_r || ready_i;

  // Shift the new sample in at tap 0; the oldest one drops out.
  always_comb begin
    taps_nxt = taps_r;
    if (valid_i && ready_o) begin
      for (int i = fir16_pkg::TAP_COUNT - 1; i > 0; i--) begin
        taps_nxt[i] = taps_r[i-1];
      end
      taps_nxt[0] = sample_i;
    end
  end

  // The delay line is filter state, so reset clears it along with the valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      taps_r  <= '0;
    end else begin
      if (ready_o) begin
        valid_r <= valid_i;
      end
      taps_r <= taps_nxt;
    end
  end

  assign valid_o = valid_r;
  assign taps_o  = taps_r;

endmodule

// ===== hw/rtl/fir16_partial.sv =====
// Weighted tap products summed in groups of four, one register per group.
// Depends on fir16_pkg for widths, types and the tap weight function.
module fir16_partial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fir16_pkg::tap_vec_t  taps_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fir16_pkg::part_vec_t part_o
);

  logic                 valid_r;
  fir16_pkg::part_vec_t part_r;
  fir16_pkg::part_vec_t part_nxt;

  assign ready_o = !valid_r || ready_i;

  // Each group adds its constant-weight products; sums wrap at the accumulator width.
  always_comb begin
    part_nxt = '0;
    for (int g = 0; g < fir16_pkg::GROUP_COUNT; g++) begin
      for (int k = 0; k < fir16_pkg::GROUP_SIZE; k++) begin
        if (g * fir16_pkg::GROUP_SIZE + k < fir16_pkg::TAP_COUNT) begin
          part_nxt[g] = part_nxt[g]
            + fir16_pkg::acc_t'(taps_i[g * fir16_pkg::GROUP_SIZE + k])
            * fir16_pkg::acc_t'({1'b0,
                fir16_pkg::tap_weight(g * fir16_pkg::GROUP_SIZE + k)});
        end
      end
    end
  end

  // Partial sums need no reset; only the valid flag does.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      part_r <= part_nxt;
    end
  end

  assign valid_o = valid_r;
  assign part_o  = part_r;

endmodule

// ===== hw/rtl/fir16_scale.sv =====
// Final sum, three-quarter scaling with floor rounding, saturation and result register.
// Depends on fir16_pkg for widths, types and the saturation limits.
module fir16_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  fir16_pkg::part_vec_t part_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output fir16_pkg::sample_t   result_o
);

  logic               valid_r;
  fir16_pkg::sample_t result_r;
  fir16_pkg::sample_t result_nxt;
  fir16_pkg::acc_t    sum;
  fir16_pkg::scaled_t triple;
  fir16_pkg::scaled_t scaled;

  assign ready_o = !valid_r || ready_i;

  // Add the partial sums, form 3*sum as a shift and add, then floor-divide by four.
  always_comb begin
    sum = '0;
    for (int g = 0; g < fir16_pkg::GROUP_COUNT; g++) begin
      sum = sum + part_i[g];
    end
    triple = (fir16_pkg::scaled_t'(sum) <<< 1) + fir16_pkg::scaled_t'(sum);
    scaled = triple >>> 2;
  end

  // Clamp to the signed 8-bit range.
  always_comb begin
    priority if (scaled > fir16_pkg::scaled_t'(fir16_pkg::OUT_MAX)) begin
      result_nxt = fir16_pkg::sample_t'(fir16_pkg::OUT_MAX);
    end else if (scaled < fir16_pkg::scaled_t'(fir16_pkg::OUT_MIN)) begin
      result_nxt = fir16_pkg::sample_t'(fir16_pkg::OUT_MIN);
    end else begin
      result_nxt = scaled[fir16_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      result_r <= result_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;

endmodule

// ===== hw/rtl/fir16_scaled_saturating.sv =====
// 16-tap symmetric FIR filter with 3/4 scaling and saturation to signed 8 bits.
// Instantiates fir16_delay, fir16_partial and fir16_scale; uses fir16_pkg.
//
// Usage:
//   in_*  : stream input; one signed 8-bit sample per transfer in in_tdata.
//   out_* : stream output; one filtered signed 8-bit sample per input transfer.
//   Weights are 1,2,...,8,8,...,2,1 over the newest sample and the 15 before it.
//   The weighted sum is multiplied by 3 and shifted right by 2 (floor), then
//   clamped to -128..127.
//   An accepted input passes the delay line, partial sums and result register
//   in that order. Throughput: one sample per cycle unless the receiver stalls;
//   each of the three stages holds one item and hands it on whenever the next
//   stage is empty or moving.
//   Reset (rst_n low, synchronous) clears the delay line to zero and empties
//   the pipeline; out_tvalid is low after reset.
//   When the receiver stalls, the result waits in the output register and the
//   earlier stages keep filling until all three are occupied; only then does
//   in_tready drop. No sample is lost or repeated.
module fir16_scaled_saturating (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] sample_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] filtered_out
);

  logic                 taps_valid;
  logic                 taps_ready;
  fir16_pkg::tap_vec_t  taps;
  logic                 part_valid;
  logic                 part_ready;
  fir16_pkg::part_vec_t parts;
  fir16_pkg::sample_t   result;

  // Input register and delay line.
  fir16_delay u_delay (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_tvalid),
    .ready_o  (in_tready),
    .sample_i (fir16_pkg::sample_t'(in_tdata)),
    .valid_o  (taps_valid),
    .ready_i  (taps_ready),
    .taps_o   (taps)
  );

  // Weighted group sums.
  fir16_partial u_partial (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (taps_valid),
    .ready_o (taps_ready),
    .taps_i  (taps),
    .valid_o (part_valid),
    .ready_i (part_ready),
    .part_o  (parts)
  );

  // Scaling, saturation and output register.
  fir16_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (part_valid),
    .ready_o  (part_ready),
    .part_i   (parts),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready),
    .result_o (result)
  );

  assign out_tdata = result;

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // The input side only stalls when every stage is full behind a stalled receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (taps_valid && part_valid && out_tvalid && !out_tready))
    else $error("input stalled without back pressure");

  // With the receiver ready, an accepted sample reaches the output through all stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready |-> ##1 out_tvalid)
    else $error("result did not arrive within three cycles");

endmodule
